FILE: src/wmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed mean filter package
// Shared field widths, payload types and the control and status bundles
// that pass between the filter and its serial divider.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned HELD_W   = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [HELD_W-1:0]   held_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/wmf_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one signed sample per word.
// ----------------------------------------------------------------------------
interface wmf_sample_if
  import wmf_pkg::*;
();

  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);

endinterface

FILE: src/wmf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the window mean and the sample count.
// ----------------------------------------------------------------------------
interface wmf_result_if
  import wmf_pkg::*;
();

  logic    valid;
  logic    ready;
  sample_t window_mean;
  held_t   samples_held;

  modport source (output valid, output window_mean, output samples_held, input ready);
  modport sink   (input valid, input window_mean, input samples_held, output ready);

endinterface

FILE: src/wmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/wmf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division that retires one quotient bit per cycle. The quotient
// is truncated toward zero and held until the consumer acknowledges it.
// ----------------------------------------------------------------------------
module wmf_div
  import wmf_pkg::*;
#(
  parameter int unsigned TOTAL_W = 21,
  parameter int unsigned COUNT_W = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  div_ctl_t                  ctl_i,
  input  logic signed [TOTAL_W-1:0] dividend_i,
  input  logic [COUNT_W-1:0]        divisor_i,
  output div_stat_t                 stat_o,
  output sample_t                   quotient_o
);

  localparam int unsigned STEP_W = $clog2(TOTAL_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [TOTAL_W-1:0] quo_q, quo_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] divisor_q, divisor_d;
  logic               neg_q, neg_d;

  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   trial_diff;
  logic               trial_ge;
  logic [TOTAL_W-1:0] magnitude;
  logic [TOTAL_W-1:0] quo_signed;

  // The dividend enters the quotient register and leaves it from the top,
  // one bit per cycle, while quotient bits shift in at the bottom.
  assign trial      = {rem_q, quo_q[TOTAL_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor_q});
  assign trial_diff = trial - {1'b0, divisor_q};
  assign magnitude  = dividend_i[TOTAL_W-1] ? (~dividend_i + TOTAL_W'(1)) : dividend_i;
  assign quo_signed = neg_q ? (~quo_q + TOTAL_W'(1)) : quo_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    neg_d     = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          quo_d     = magnitude;
          rem_d     = '0;
          divisor_d = divisor_i;
          neg_d     = dividend_i[TOTAL_W-1];
          step_d    = STEP_W'(TOTAL_W);
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d  = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quo_d  = {quo_q[TOTAL_W-2:0], trial_ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    neg_q     <= neg_d;
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign quotient_o  = $signed(quo_signed[SAMPLE_W-1:0]);

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q != '0 && step_q <= STEP_W'(TOTAL_W)))
    else $error("divider step count out of range");

  a_run_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_W'(1)) |=> (state_q == ST_DONE))
    else $error("divider did not finish after its last step");
`endif

endmodule

FILE: src/windowed_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed mean filter
// Moving average over the most recent WINDOW_DEPTH signed samples.
// ----------------------------------------------------------------------------
// Each sample word yields one result word: the mean of the samples held, the
// new one included, truncated toward zero, together with the number of
// samples averaged (saturating at WINDOW_DEPTH, reported in 5 bits). Until the
// window has filled, the mean covers only the samples received since reset.
// After a word is accepted, no further word is accepted until its result
// has moved to the output register. The window is read, the running total
// is updated and the divider is loaded; the bit-serial divider then works
// through TOTAL_W = 17 + clog2(WINDOW_DEPTH) bits, one quotient bit per
// cycle, and the quotient is handed to the output register once that
// register is free. A finished result waits in the output register while the
// next sample is accepted.
module windowed_mean_filter
  import wmf_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  wmf_sample_if.sink   sample_i,
  wmf_result_if.source result_o
);

  localparam int unsigned COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TOTAL_W = SAMPLE_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int unsigned ADDR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(WINDOW_DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(WINDOW_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_START  = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic signed [TOTAL_W-1:0] total_q, total_d;
  logic [ADDR_W-1:0]         wptr_q, wptr_d;
  logic                      was_full_q, was_full_d;
  sample_t                   sample_q, sample_d;
  logic                      out_valid_q, out_valid_d;
  sample_t                   out_mean_q, out_mean_d;
  held_t                     out_held_q, out_held_d;

  logic                      in_accept;
  logic                      out_free;
  logic                      ram_we;
  logic                      ram_re;
  logic [SAMPLE_W-1:0]       ram_rdata;
  logic signed [TOTAL_W-1:0] add_term;
  logic signed [TOTAL_W-1:0] sub_term;
  logic [HELD_W+COUNT_W-1:0] held_wide;
  div_ctl_t                  div_ctl;
  div_stat_t                 div_stat;
  sample_t                   div_quotient;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_accept      = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;

  // The oldest sample sits at the write pointer once the window is full, so
  // it is read there first and overwritten by the new sample in the following cycle.
  assign ram_re = in_accept;
  assign ram_we = (state_q == ST_UPDATE);

  assign add_term  = {{(TOTAL_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign sub_term  = was_full_q ? {{(TOTAL_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata}
                                : '0;
  assign held_wide = {{HELD_W{1'b0}}, count_q};

  assign div_ctl.start = (state_q == ST_START);
  assign div_ctl.ack   = (state_q == ST_WAIT) && div_stat.done && out_free;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    wptr_d      = wptr_q;
    was_full_d  = was_full_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_held_d  = out_held_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sample_d   = sample_i.sample_value;
          was_full_d = (count_q == DEPTH_COUNT);
          if (count_q != DEPTH_COUNT) begin
            count_d = count_q + COUNT_W'(1);
          end
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        total_d = total_q + add_term - sub_term;
        wptr_d  = (wptr_q == LAST_ADDR) ? '0 : wptr_q + ADDR_W'(1);
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_ctl.ack) begin
          out_valid_d = 1'b1;
          out_mean_d  = div_quotient;
          out_held_d  = held_wide[HELD_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      wptr_q      <= wptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    was_full_q <= was_full_d;
    sample_q   <= sample_d;
    out_mean_q <= out_mean_d;
    out_held_q <= out_held_d;
  end

  wmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (wptr_q),
    .rdata_o (ram_rdata)
  );

  wmf_div #(
    .TOTAL_W (TOTAL_W),
    .COUNT_W (COUNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (total_q),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quotient_o (div_quotient)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.window_mean  = out_mean_q;
  assign result_o.samples_held = out_held_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_COUNT)
    else $error("fill count exceeds window depth");

  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_UPDATE && count_q != '0))
    else $error("accepted word did not move to the total update");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !sample_i.ready)
    else $error("sample accepted while the divider is busy");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.ack |=> (result_o.valid && state_q == ST_IDLE && !div_stat.busy))
    else $error("divider result was not handed to the output register");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed mean filter testbench
// Sends signed samples into the filter and checks each result word against a
// moving-average predictor kept in the bench. A directed opening covers the
// extremes, the first words after reset and the sliding of a full window.
// Random samples follow, in blocks with different value profiles. Both
// channels insert idle gaps at random.
// ----------------------------------------------------------------------------
module tb;
  import wmf_pkg::*;

  localparam int unsigned WINDOW_DEPTH   = 16;
  localparam int unsigned WORD_CYCLES    = 17 + $clog2(WINDOW_DEPTH) + 4;
  localparam int unsigned DRAIN_CYCLES   = 2 * WORD_CYCLES;
  localparam int unsigned RANDOM_WORDS   = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum int unsigned {
    PROFILE_UNIFORM,
    PROFILE_HIGH,
    PROFILE_LOW,
    PROFILE_NEAR_ZERO,
    PROFILE_EXTREMES
  } sample_profile_e;

  typedef struct {
    sample_t     value;
    int unsigned gap;
  } sample_word_t;

  typedef struct {
    sample_t mean;
    held_t   held;
  } mean_word_t;

  logic clk_i;
  logic rst_ni;

  wmf_sample_if sample_if ();
  wmf_result_if result_if ();

  windowed_mean_filter #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if)
  );

  sample_word_t pending_q[$];
  mean_word_t   mean_due_q[$];

  // Bench copy of the filter state.
  sample_t     window_hist[WINDOW_DEPTH];
  int          held_count;
  longint      window_sum;

  int unsigned hold_off;
  int unsigned stall_left;
  bit          steady_sink;
  int unsigned error_count;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned full_window_results;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic push_and_average(input sample_t value);
    mean_word_t due;
    if (held_count >= WINDOW_DEPTH) begin
      // The oldest sample drops out of the total before the new one enters.
      window_sum -= window_hist[WINDOW_DEPTH-1];
      held_count = WINDOW_DEPTH;
    end else begin
      held_count++;
    end
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_hist[i] = window_hist[i-1];
    window_hist[0] = value;
    window_sum += value;
    // Signed division in SystemVerilog truncates toward zero.
    due.mean = sample_t'(window_sum / held_count);
    due.held = held_t'(held_count);
    if (held_count == WINDOW_DEPTH) full_window_results++;
    mean_due_q.push_back(due);
  endtask

  // Sample driver: one word in flight, followed by its own idle gap.
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    sample_word_t word;
    if (!rst_ni) begin
      sample_if.valid        <= 1'b0;
      sample_if.sample_value <= '0;
      hold_off               <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        push_and_average(sample_if.sample_value);
        samples_sent++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (hold_off != 0) begin
          hold_off        <= hold_off - 1;
          sample_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          word = pending_q.pop_front();
          sample_if.valid        <= 1'b1;
          sample_if.sample_value <= word.value;
          hold_off               <= word.gap;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted word and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    mean_word_t  due;
    int unsigned stall;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
      steady_sink     <= 1'b0;
    end else if (result_if.valid && result_if.ready) begin
      if (mean_due_q.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("ERROR: unexpected result word mean=%0d held=%0d",
                   result_if.window_mean, result_if.samples_held);
        error_count++;
      end else begin
        due = mean_due_q.pop_front();
        results_checked++;
        if (result_if.window_mean !== due.mean || result_if.samples_held !== due.held) begin
          if (error_count < REPORT_LIMIT)
            $display("ERROR: result %0d expected mean=%0d held=%0d, got mean=%0d held=%0d",
                     results_checked, due.mean, due.held,
                     result_if.window_mean, result_if.samples_held);
          error_count++;
        end
      end
      if ($urandom_range(0, 99) == 0) steady_sink <= ~steady_sink;
      stall = steady_sink ? 0 : idle_length();
      stall_left      <= stall;
      result_if.ready <= (stall == 0);
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= (stall_left == 1);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    sample_word_t    word;
    sample_profile_e profile;
    bit              no_gaps;
    sample_t         opening[$];

    rst_ni      = 1'b0;
    held_count  = 0;
    window_sum  = 0;
    error_count = 0;
    foreach (window_hist[i]) window_hist[i] = '0;

    // Opening: full-scale extremes from an empty window, a negative mean that
    // must truncate toward zero, then a window filled with the positive
    // maximum and slid over by the negative minimum.
    opening.push_back(sample_t'(-32768));
    opening.push_back(sample_t'(-1));
    repeat (WINDOW_DEPTH) opening.push_back(sample_t'(32767));
    repeat (5) opening.push_back(sample_t'(-32768));
    opening.push_back(sample_t'(0));
    foreach (opening[i]) begin
      word.value = opening[i];
      word.gap   = idle_length();
      pending_q.push_back(word);
    end

    // Random part in blocks, each with its own value profile; some blocks
    // run back to back with no gaps at all.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        profile = sample_profile_e'($urandom_range(0, 4));
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      case (profile)
        PROFILE_HIGH:      word.value = sample_t'(32767 - $urandom_range(0, 255));
        PROFILE_LOW:       word.value = sample_t'(-32768 + $urandom_range(0, 255));
        PROFILE_NEAR_ZERO: word.value = sample_t'($urandom_range(0, 16) - 8);
        PROFILE_EXTREMES: begin
          word.value = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
        end
        default:           word.value = sample_t'($urandom_range(0, 65535));
      endcase
      word.gap = no_gaps ? 0 : idle_length();
      pending_q.push_back(word);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || sample_if.valid || mean_due_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples and checked %0d result words, %0d of them over a full window.",
             samples_sent, results_checked, full_window_results);
    $display("Mismatches and stray words: %0d.", error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
